// ===== sv/sfw_pkg.sv =====
// Shared definitions for the first-primes sieve writer.
// Field widths, parameter defaults and the fixed first prime; no dependencies.
`default_nettype none

package sfw_pkg;

	// Widths of the transfer fields.
	localparam int COUNT_W = 6;
	localparam int SLOT_W  = 5;
	localparam int PRIME_W = 8;

	// Default sizing of the run and of the sieve.
	localparam int DEF_NUM_SLOTS   = 32;
	localparam int DEF_SIEVE_LIMIT = 140;

	// The only even prime, which occupies slot 0 whenever at least one prime is wanted.
	localparam logic [PRIME_W-1:0] FIRST_PRIME = 8'd2;

endpackage

`default_nettype wire

// ===== sv/sfw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module sfw_ram #(
	parameter int WIDTH  = 1,
	parameter int DEPTH  = 2,
	parameter int ADDR_W = 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== sv/sfw_front.sv =====
// Front end of the sieve writer: accepts requests, clamps the wanted count
// to the slot count and holds them in a two-entry queue. Uses sfw_pkg.
`default_nettype none

module sfw_front #(
	parameter int NUM_SLOTS = 32,
	parameter int CNT_W     = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [sfw_pkg::COUNT_W-1:0] count_wanted,
	output logic                             req_valid,
	output logic      [CNT_W-1:0]            req_want,
	input  wire logic                        req_pop
);

	import sfw_pkg::*;

	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	logic [CNT_W-1:0] want_clamped;
	logic [CNT_W-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             pop;

	// A request for more primes than slots is cut down to the slot count.
	always_comb begin
		if (CMP_W'(count_wanted) > CMP_W'(NUM_SLOTS)) begin
			want_clamped = CNT_W'(NUM_SLOTS);
		end else begin
			want_clamped = CNT_W'(count_wanted);
		end
	end

	// Queue handshake.
	assign in_stall  = (fill_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign req_valid = (fill_q != 2'd0);
	assign pop       = req_pop && req_valid;
	assign req_want  = entry_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= want_clamped;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/sfw_back.sv =====
// Back end of the sieve writer: clears the odd-number mark memory, walks the
// candidates, crosses out multiples and emits the run of words. Uses sfw_pkg, sfw_ram.
`default_nettype none

module sfw_back #(
	parameter int NUM_SLOTS   = 32,
	parameter int SIEVE_LIMIT = 140,
	parameter int CNT_W       = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	input  wire logic [CNT_W-1:0]            req_want,
	output logic                             req_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [sfw_pkg::SLOT_W-1:0]  slot_index,
	output logic      [sfw_pkg::PRIME_W-1:0] prime_value,
	output logic                             last_word
);

	import sfw_pkg::*;

	// Marks are kept for odd numbers only: entry i stands for 2i+1.
	localparam int ODD_N = SIEVE_LIMIT / 2;
	localparam int IDX_W = (ODD_N > 1) ? $clog2(ODD_N) : 1;
	localparam int CI_W  = $clog2(ODD_N + 1);
	localparam int MI_W  = $clog2(3 * ODD_N + 2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_HEAD,
		ST_READ,
		ST_TEST,
		ST_CROSS,
		ST_PAD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] want_q;
	logic [CNT_W-1:0] slot_q;
	logic [CI_W-1:0]  ci_q;
	logic [MI_W-1:0]  mi_q;
	logic             out_valid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [PRIME_W-1:0] out_prime_q;
	logic             out_last_q;

	logic             out_free;
	logic             emit;
	logic             slot_last;
	logic [CI_W:0]    cand;
	logic [MI_W-1:0]  cross_start;
	logic [MI_W-1:0]  cross_next;
	logic [CI_W+PRIME_W:0]  cand_wide;
	logic [CNT_W+SLOT_W-1:0] slot_wide;
	logic             mark_we;
	logic             mark_wdata;
	logic             mark_rdata;

	// Output register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	assign slot_last = (slot_q == CNT_W'(NUM_SLOTS - 1));

	// A word is loaded into the output register in this cycle.
	assign emit = out_free && ((state_q == ST_HEAD) || (state_q == ST_PAD) ||
		((state_q == ST_TEST) && !mark_rdata));

	// Candidate value and crossing addresses; stepping the odd index by p
	// moves from one odd multiple of p to the next.
	assign cand        = {ci_q, 1'b1};
	assign cand_wide   = {{PRIME_W{1'b0}}, cand};
	assign slot_wide   = {{SLOT_W{1'b0}}, slot_q};
	assign cross_start = MI_W'(ci_q) + MI_W'(cand);
	assign cross_next  = mi_q + MI_W'(cand);

	// Mark memory write side: zeros while clearing, ones while crossing out.
	assign mark_we    = (state_q == ST_CLEAR) || (state_q == ST_CROSS);
	assign mark_wdata = (state_q == ST_CROSS);

	sfw_ram #(
		.WIDTH (1),
		.DEPTH (ODD_N),
		.ADDR_W(IDX_W)
	) u_marks (
		.clk    (clk),
		.wr_en  (mark_we),
		.wr_addr(mi_q[IDX_W-1:0]),
		.wr_data(mark_wdata),
		.rd_addr(ci_q[IDX_W-1:0]),
		.rd_data(mark_rdata)
	);

	assign req_pop     = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign slot_index  = out_slot_q;
	assign prime_value = out_prime_q;
	assign last_word   = out_last_q;

	// Sequencer with its counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			want_q      <= '0;
			slot_q      <= '0;
			ci_q        <= '0;
			mi_q        <= '0;
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_prime_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						want_q  <= req_want;
						slot_q  <= '0;
						mi_q    <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (mi_q == MI_W'(ODD_N - 1)) begin
						state_q <= ST_HEAD;
					end else begin
						mi_q <= mi_q + MI_W'(1);
					end
				end
				ST_HEAD: begin
					if (out_free) begin
						out_slot_q  <= slot_wide[SLOT_W-1:0];
						out_prime_q <= (want_q != '0) ? FIRST_PRIME : '0;
						out_last_q  <= slot_last;
						slot_q      <= slot_q + CNT_W'(1);
						ci_q        <= CI_W'(1);
						state_q     <= slot_last ? ST_IDLE : ST_READ;
					end
				end
				ST_READ: begin
					// Read address is the candidate index; data is back next cycle.
					if ((slot_q < want_q) && (ci_q < CI_W'(ODD_N))) begin
						state_q <= ST_TEST;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_TEST: begin
					if (mark_rdata) begin
						ci_q    <= ci_q + CI_W'(1);
						state_q <= ST_READ;
					end else if (out_free) begin
						out_slot_q  <= slot_wide[SLOT_W-1:0];
						out_prime_q <= cand_wide[PRIME_W-1:0];
						out_last_q  <= slot_last;
						slot_q      <= slot_q + CNT_W'(1);
						mi_q        <= cross_start;
						if (slot_last) begin
							state_q <= ST_IDLE;
						end else if (cross_start < MI_W'(ODD_N)) begin
							state_q <= ST_CROSS;
						end else begin
							ci_q    <= ci_q + CI_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_CROSS: begin
					mi_q <= cross_next;
					if (cross_next >= MI_W'(ODD_N)) begin
						ci_q    <= ci_q + CI_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_PAD: begin
					if (out_free) begin
						out_slot_q  <= slot_wide[SLOT_W-1:0];
						out_prime_q <= '0;
						out_last_q  <= slot_last;
						slot_q      <= slot_q + CNT_W'(1);
						if (slot_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/first_primes_sieve_writer.sv =====
// Top level of the first-primes sieve writer: request queue front end and
// sieve back end. Uses sfw_pkg, sfw_front, sfw_back.
//
//   Channel | Direction | Handshake          | Fields
//   in      | input     | in_valid/in_stall  | count_wanted
//   out     | output    | out_valid/out_stall| slot_index, prime_value, last_word
//
// Each request yields NUM_SLOTS output transfers. The back end takes the request,
// clears the mark memory (SIEVE_LIMIT/2 entries), emits the head word, then
// reads and tests each odd candidate (the mark memory has a registered read; a
// prime word leaves in the test state), crosses out the odd multiples of each
// prime found and emits padding words until all NUM_SLOTS slots are written.
// Reset clears all control state; the mark memory needs no reset since every
// request clears it. A stalled output holds the sequencer whenever it has a word
// to emit; the front queue keeps taking up to two requests meanwhile.
`default_nettype none

module first_primes_sieve_writer #(
	parameter int NUM_SLOTS   = sfw_pkg::DEF_NUM_SLOTS,
	parameter int SIEVE_LIMIT = sfw_pkg::DEF_SIEVE_LIMIT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [sfw_pkg::COUNT_W-1:0] count_wanted,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [sfw_pkg::SLOT_W-1:0]  slot_index,
	output logic      [sfw_pkg::PRIME_W-1:0] prime_value,
	output logic                             last_word
);

	import sfw_pkg::*;

	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	logic             req_valid;
	logic [CNT_W-1:0] req_want;
	logic             req_pop;

	// Request acceptance and queueing.
	sfw_front #(
		.NUM_SLOTS(NUM_SLOTS),
		.CNT_W    (CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.count_wanted(count_wanted),
		.req_valid   (req_valid),
		.req_want    (req_want),
		.req_pop     (req_pop)
	);

	// Sieve and word emission.
	sfw_back #(
		.NUM_SLOTS  (NUM_SLOTS),
		.SIEVE_LIMIT(SIEVE_LIMIT),
		.CNT_W      (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_want   (req_want),
		.req_pop    (req_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_index (slot_index),
		.prime_value(prime_value),
		.last_word  (last_word)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_first_primes_sieve_writer.sv =====
// Self-checking testbench for the first-primes sieve writer: random and directed prime counts,
// an in-house sieve predictor per request and a field-by-field check of every output word.
// Depends on sfw_pkg and first_primes_sieve_writer.
`default_nettype none

module tb_first_primes_sieve_writer;
	import sfw_pkg::*;

	localparam int RUN_CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES    = 300;
	localparam int HOLD_CYCLES     = 3000;
	localparam int HOLD_AFTER      = 150;
	localparam int QUIET_FROM      = 260;
	localparam int QUIET_TO        = 320;
	localparam int IDLE_PERCENT    = 21;
	localparam int RANDOM_REQUESTS = 398;

	// One output word of a run as the block should present it.
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [PRIME_W-1:0] prime;
		logic               last;
	} prime_word_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [COUNT_W-1:0]  count_wanted;
	logic                out_valid;
	logic                out_stall;
	logic [SLOT_W-1:0]   slot_index;
	logic [PRIME_W-1:0]  prime_value;
	logic                last_word;

	logic [COUNT_W-1:0]  pending_counts [$];
	prime_word_t         expected_words [$];
	int                  requests_taken;
	int                  mismatches;
	int                  cycle_count;
	int                  hold_left;
	bit                  hold_done;
	bit                  in_accepted;

	first_primes_sieve_writer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.count_wanted (count_wanted),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot_index   (slot_index),
		.prime_value  (prime_value),
		.last_word    (last_word)
	);

	// Works out the whole run of words that one request yields and queues it.
	function automatic void predict_prime_run(input logic [COUNT_W-1:0] wanted);
		bit                 crossed [DEF_SIEVE_LIMIT];
		logic [PRIME_W-1:0] run [DEF_NUM_SLOTS];
		int                 filled;
		int                 cand;
		int                 m;
		prime_word_t        w;
		foreach (crossed[i]) crossed[i] = 1'b0;
		foreach (run[i]) run[i] = '0;
		filled = 0;
		if (wanted >= 1) begin
			run[0] = FIRST_PRIME;
			filled = 1;
		end
		// Odd candidates only; each new prime crosses out its odd multiples.
		for (cand = 3; cand < DEF_SIEVE_LIMIT && filled < int'(wanted) &&
				filled < DEF_NUM_SLOTS; cand += 2) begin
			if (!crossed[cand]) begin
				for (m = cand; m < DEF_SIEVE_LIMIT; m += 2 * cand)
					crossed[m] = 1'b1;
				run[filled] = PRIME_W'(cand);
				filled++;
			end
		end
		for (int k = 0; k < DEF_NUM_SLOTS; k++) begin
			w.slot  = SLOT_W'(k);
			w.prime = run[k];
			w.last  = (k == DEF_NUM_SLOTS - 1);
			expected_words.push_back(w);
		end
	endfunction

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Requests are accepted here and their runs predicted at the same edge.
	always @(posedge clk) begin
		in_accepted <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			predict_prime_run(count_wanted);
			requests_taken <= requests_taken + 1;
		end
	end

	// Sender: a new request may follow only once the current one has been transferred.
	always @(negedge clk) begin
		logic quiet;
		if (arst_n && (!in_valid || in_accepted)) begin
			quiet = (requests_taken >= QUIET_FROM && requests_taken < QUIET_TO) ||
				hold_left > 0;
			if (pending_counts.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
			end else begin
				in_valid     <= 1'b1;
				count_wanted <= pending_counts.pop_front();
			end
		end
	end

	// Receiver: random stalls, one long hold-off to fill the block, and a quiet stretch.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (requests_taken >= QUIET_FROM && requests_taken < QUIET_TO) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
			end
		end
	end

	// Each output transfer is checked against the oldest predicted word.
	always @(posedge clk) begin
		prime_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got slot %0d prime %0d last %0b",
					$time, slot_index, prime_value, last_word);
				mismatches++;
			end else begin
				w = expected_words.pop_front();
				if (slot_index !== w.slot) begin
					$display("%0t: slot_index expected %0d, got %0d",
						$time, w.slot, slot_index);
					mismatches++;
				end
				if (prime_value !== w.prime) begin
					$display("%0t: prime_value at slot %0d expected %0d, got %0d",
						$time, w.slot, w.prime, prime_value);
					mismatches++;
				end
				if (last_word !== w.last) begin
					$display("%0t: last_word at slot %0d expected %0b, got %0b",
						$time, w.slot, w.last, last_word);
					mismatches++;
				end
			end
		end
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d words outstanding",
				$time, expected_words.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Stimulus, reset and the end of the run.
	initial begin
		logic [COUNT_W-1:0] directed [] = '{
			6'd0, 6'd1, 6'd2, 6'd3, 6'd31, 6'd32, 6'd33, 6'd34, 6'd63, 6'd62,
			6'd42, 6'd21, 6'd16, 6'd0, 6'd5, 6'd10, 6'd63, 6'd4, 6'd8, 6'd30};
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		out_stall      = 1'b0;
		count_wanted   = '0;
		requests_taken = 0;
		mismatches     = 0;
		cycle_count    = 0;
		hold_left      = 0;
		hold_done      = 1'b0;
		in_accepted    = 1'b0;

		foreach (directed[i]) pending_counts.push_back(directed[i]);
		// Mostly counts within the slot range, some beyond it.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if ($urandom_range(0, 99) < 80)
				pending_counts.push_back(COUNT_W'($urandom_range(0, DEF_NUM_SLOTS)));
			else
				pending_counts.push_back(COUNT_W'($urandom_range(DEF_NUM_SLOTS + 1, 63)));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_counts.size() != 0 || in_valid) @(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
